[hdl/brs_pkg.sv]
package brs_pkg;

    localparam int NUM_SOURCES = 2;
    localparam int SRC_W       = 2;
    localparam int TIME_W      = 32;
    localparam int CNT_W       = 8;
    localparam int NOTE_W      = 3;
    localparam int NMASK_W     = 5;
    localparam int FUNC_W      = 2;
    localparam int OUTCOME_W   = 2;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [SRC_W-1:0] SRC_MASK = SRC_W'((1 << NUM_SOURCES) - 1);

    localparam logic [TIME_W-1:0] RESET_RETRY_DELAY   = 32'd10;
    localparam logic [CNT_W-1:0]  RESET_ATTEMPT_LIMIT = 8'd3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SERVICE     = 2'd0,
        FUNC_REQUEST     = 2'd1,
        FUNC_TAKE_RESULT = 2'd2,
        FUNC_TAKE_NOTICE = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        MODE_READY      = 4'b0001,
        MODE_WAIT       = 4'b0010,
        MODE_RECOVERING = 4'b0100,
        MODE_ERROR      = 4'b1000
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RETRY_DELAY   = 1'b0,
        REG_ATTEMPT_LIMIT = 1'b1
    } cfg_reg_t;

    localparam logic [MODE_W-1:0] MODE_CODE_READY      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_WAIT       = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_RECOVERING = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CODE_ERROR      = 2'd3;

    localparam logic [OUTCOME_W-1:0] OUTCOME_SUCCEEDED = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_FAILED    = 2'd2;

    localparam logic [NOTE_W-1:0] NOTE_NONE      = 3'd0;
    localparam logic [NOTE_W-1:0] NOTE_PENDING   = 3'd1;
    localparam logic [NOTE_W-1:0] NOTE_STARTED   = 3'd2;
    localparam logic [NOTE_W-1:0] NOTE_RETRY     = 3'd3;
    localparam logic [NOTE_W-1:0] NOTE_SUCCEEDED = 3'd4;
    localparam logic [NOTE_W-1:0] NOTE_FAILED    = 3'd5;

    typedef struct packed {
        func_t                 func;
        logic [TIME_W-1:0]     now_ms;
        logic [SRC_W-1:0]      request_sources;
        logic                  start_accepted;
        logic [OUTCOME_W-1:0]  engine_outcome;
        logic                  reinit_ok;
    } item_t;

    typedef struct packed {
        mode_t               mode;
        logic [TIME_W-1:0]   entry_time;
        logic [CNT_W-1:0]    attempt_count;
        logic [SRC_W-1:0]    pending_sources;
        logic [SRC_W-1:0]    done_sources;
        logic                result_waiting;
        logic                last_result;
        logic [NMASK_W-1:0]  notice_mask;
        logic                bus_ready;
        logic                error_flag;
    } state_t;

    typedef struct packed {
        logic                accepted;
        logic [MODE_W-1:0]   mode;
        logic                start_pulse;
        logic                reinit_pulse;
        logic                result_code;
        logic [SRC_W-1:0]    result_sources;
        logic [NOTE_W-1:0]   notice;
        logic [CNT_W-1:0]    attempts;
        logic                fault;
    } result_t;

    function automatic logic [MODE_W-1:0] mode_code(mode_t m);
        logic [MODE_W-1:0] code;
        unique case (m)
            MODE_READY:      code = MODE_CODE_READY;
            MODE_WAIT:       code = MODE_CODE_WAIT;
            MODE_RECOVERING: code = MODE_CODE_RECOVERING;
            MODE_ERROR:      code = MODE_CODE_ERROR;
            default:         code = MODE_CODE_ERROR;
        endcase
        return code;
    endfunction

    // Bit n-1 of the pending mask holds notification n.
    function automatic logic [NMASK_W-1:0] note_bit(logic [NOTE_W-1:0] n);
        return NMASK_W'(1) << (n - NOTE_W'(1));
    endfunction

endpackage

[hdl/brs_ifs.sv]
interface brs_item_if import brs_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [FUNC_W-1:0]     func;
    logic [TIME_W-1:0]     now_ms;
    logic [SRC_W-1:0]      request_sources;
    logic                  start_accepted;
    logic [OUTCOME_W-1:0]  engine_outcome;
    logic                  reinit_ok;

    modport source (
        output valid, func, now_ms, request_sources, start_accepted, engine_outcome,
               reinit_ok,
        input  ready
    );
    modport sink (
        input  valid, func, now_ms, request_sources, start_accepted, engine_outcome,
               reinit_ok,
        output ready
    );
endinterface

interface brs_result_if import brs_pkg::*;;
    logic                valid;
    logic                ready;
    logic                accepted;
    logic [MODE_W-1:0]   mode;
    logic                start_pulse;
    logic                reinit_pulse;
    logic                result_code;
    logic [SRC_W-1:0]    result_sources;
    logic [NOTE_W-1:0]   notice;
    logic [CNT_W-1:0]    attempts;
    logic                fault;

    modport source (
        output valid, accepted, mode, start_pulse, reinit_pulse, result_code,
               result_sources, notice, attempts, fault,
        input  ready
    );
    modport sink (
        input  valid, accepted, mode, start_pulse, reinit_pulse, result_code,
               result_sources, notice, attempts, fault,
        output ready
    );
endinterface

interface brs_cfg_if import brs_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

[hdl/brs_step.sv]
module brs_step import brs_pkg::*;
(
    input  state_t             state,
    input  item_t              item,
    input  logic [TIME_W-1:0]  retry_delay,
    input  logic [CNT_W-1:0]   attempt_limit,
    output state_t             state_next,
    output result_t            res
);

    logic [TIME_W-1:0]  elapsed;
    logic [CNT_W-1:0]   count_inc;
    logic [SRC_W-1:0]   src;

    assign elapsed   = item.now_ms - state.entry_time;
    assign count_inc = state.attempt_count + CNT_W'(1);
    assign src       = item.request_sources & SRC_MASK;

    always_comb
    begin
        state_t  nxt;
        result_t r;
        logic    finish;
        logic    found;

        nxt    = state;
        r      = '0;
        finish = 1'b0;
        found  = 1'b0;

        unique case (item.func)
            FUNC_SERVICE:
            begin
                unique case (state.mode)
                    MODE_WAIT:
                    begin
                        if (elapsed >= retry_delay)
                        begin
                            if (state.attempt_count >= attempt_limit)
                            begin
                                finish = 1'b1;
                            end
                            else
                            begin
                                nxt.attempt_count = count_inc;
                                r.start_pulse     = 1'b1;
                                priority if (item.start_accepted)
                                begin
                                    nxt.mode        = MODE_RECOVERING;
                                    nxt.entry_time  = item.now_ms;
                                    nxt.notice_mask = nxt.notice_mask | note_bit(NOTE_STARTED);
                                end
                                else if (count_inc < attempt_limit)
                                begin
                                    nxt.entry_time  = item.now_ms;
                                    nxt.notice_mask = nxt.notice_mask | note_bit(NOTE_RETRY);
                                end
                                else
                                begin
                                    r.reinit_pulse = 1'b1;
                                    nxt.bus_ready  = item.reinit_ok;
                                    finish         = 1'b1;
                                end
                            end
                        end
                    end
                    MODE_RECOVERING:
                    begin
                        if (item.engine_outcome == OUTCOME_SUCCEEDED)
                        begin
                            r.reinit_pulse = 1'b1;
                            nxt.bus_ready  = item.reinit_ok;
                            finish         = 1'b1;
                        end
                        else if (item.engine_outcome == OUTCOME_FAILED)
                        begin
                            r.reinit_pulse = 1'b1;
                            nxt.bus_ready  = item.reinit_ok;
                            if (state.attempt_count < attempt_limit)
                            begin
                                nxt.mode        = MODE_WAIT;
                                nxt.entry_time  = item.now_ms;
                                nxt.notice_mask = nxt.notice_mask | note_bit(NOTE_RETRY);
                            end
                            else
                            begin
                                finish = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            FUNC_REQUEST:
            begin
                if (src != '0 && state.mode != MODE_ERROR)
                begin
                    r.accepted          = 1'b1;
                    nxt.pending_sources = state.pending_sources | src;
                    if (state.mode == MODE_READY)
                    begin
                        nxt.attempt_count  = '0;
                        nxt.result_waiting = 1'b0;
                        nxt.done_sources   = '0;
                        nxt.mode           = MODE_WAIT;
                        nxt.entry_time     = item.now_ms;
                        nxt.notice_mask    = nxt.notice_mask | note_bit(NOTE_PENDING);
                    end
                end
            end
            FUNC_TAKE_RESULT:
            begin
                if (state.result_waiting)
                begin
                    r.accepted         = 1'b1;
                    r.result_code      = state.last_result;
                    r.result_sources   = state.done_sources;
                    nxt.result_waiting = 1'b0;
                end
            end
            FUNC_TAKE_NOTICE:
            begin
                // pop the lowest pending notification
                for (int k = 0; k < NMASK_W; k++)
                begin
                    if (!found && state.notice_mask[k])
                    begin
                        found              = 1'b1;
                        nxt.notice_mask[k] = 1'b0;
                        r.notice           = NOTE_W'(k + 1);
                        r.accepted         = 1'b1;
                    end
                end
            end
        endcase

        // Every finish path is failed except a success with a good reinit.
        if (finish)
        begin
            nxt.last_result     = !r.reinit_pulse || !item.reinit_ok ||
                                  item.func != FUNC_SERVICE ||
                                  state.mode != MODE_RECOVERING ||
                                  item.engine_outcome != OUTCOME_SUCCEEDED;
            nxt.result_waiting  = 1'b1;
            nxt.done_sources    = state.pending_sources;
            nxt.pending_sources = '0;
            nxt.error_flag      = nxt.last_result;
            nxt.mode            = nxt.bus_ready ? MODE_READY : MODE_ERROR;
            nxt.entry_time      = item.now_ms;
            nxt.notice_mask     = nxt.notice_mask |
                                  note_bit(nxt.last_result ? NOTE_FAILED : NOTE_SUCCEEDED);
        end

        r.mode     = mode_code(nxt.mode);
        r.attempts = nxt.attempt_count;
        r.fault    = nxt.error_flag;

        state_next = nxt;
        res        = r;
    end

endmodule

[hdl/bus_recovery_supervisor.sv]
// Recovery supervisor for a shared serial bus. Each item (service tick, recovery
// request, take result, take notification) is latched into an input register,
// evaluated against the supervisor state in one combinational pass, and the
// result lands in an output register. One item per cycle is sustained while the
// result side is ready; the single state update path sets that rate, and a stalled
// result holds the input register while the next item waits at the item port. The
// configuration port is always ready and takes retry_delay (index 0, ms) and
// attempt_limit (index 1); write it only while no item is in flight.
module bus_recovery_supervisor import brs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    brs_cfg_if.sink      cfg,
    brs_item_if.sink     item,
    brs_result_if.source result
);

    logic [TIME_W-1:0]  retry_delay_reg;
    logic [CNT_W-1:0]   attempt_limit_reg;
    logic               item_valid_reg;
    item_t              item_reg;
    state_t             state_reg;
    state_t             state_next;
    logic               result_valid_reg;
    result_t            result_reg;
    result_t            result_next;
    logic               advance;

    assign advance    = item_valid_reg && (!result_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_delay_reg   <= RESET_RETRY_DELAY;
            attempt_limit_reg <= RESET_ATTEMPT_LIMIT;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_RETRY_DELAY:   retry_delay_reg   <= cfg.data[TIME_W-1:0];
                REG_ATTEMPT_LIMIT: attempt_limit_reg <= cfg.data[CNT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            item_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg.func            <= func_t'(item.func);
            item_reg.now_ms          <= item.now_ms;
            item_reg.request_sources <= item.request_sources;
            item_reg.start_accepted  <= item.start_accepted;
            item_reg.engine_outcome  <= item.engine_outcome;
            item_reg.reinit_ok       <= item.reinit_ok;
        end
    end

    brs_step u_step (
        .state         (state_reg),
        .item          (item_reg),
        .retry_delay   (retry_delay_reg),
        .attempt_limit (attempt_limit_reg),
        .state_next    (state_next),
        .res           (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode            <= MODE_READY;
            state_reg.entry_time      <= '0;
            state_reg.attempt_count   <= '0;
            state_reg.pending_sources <= '0;
            state_reg.done_sources    <= '0;
            state_reg.result_waiting  <= 1'b0;
            state_reg.last_result     <= 1'b0;
            state_reg.notice_mask     <= '0;
            state_reg.bus_ready       <= 1'b1;
            state_reg.error_flag      <= 1'b0;
            result_valid_reg          <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid          = result_valid_reg;
    assign result.accepted       = result_reg.accepted;
    assign result.mode           = result_reg.mode;
    assign result.start_pulse    = result_reg.start_pulse;
    assign result.reinit_pulse   = result_reg.reinit_pulse;
    assign result.result_code    = result_reg.result_code;
    assign result.result_sources = result_reg.result_sources;
    assign result.notice         = result_reg.notice;
    assign result.attempts       = result_reg.attempts;
    assign result.fault          = result_reg.fault;

endmodule

[hdl/brs_checker.sv]
module brs_checker import brs_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               result_ready,
    input logic               accepted,
    input logic [MODE_W-1:0]  mode,
    input logic               start_pulse,
    input logic [NOTE_W-1:0]  notice,
    input logic [CNT_W-1:0]   attempts,
    input logic               fault
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    // error mode is only reached through a failed episode
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && mode == MODE_CODE_ERROR |-> fault)
        else $error("error mode without fault");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && start_pulse |-> attempts != '0)
        else $error("start attempted with zero attempt count");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && notice != NOTE_NONE |-> accepted)
        else $error("notification delivered without accept");

endmodule

bind bus_recovery_supervisor brs_checker u_brs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .accepted     (result.accepted),
    .mode         (result.mode),
    .start_pulse  (result.start_pulse),
    .notice       (result.notice),
    .attempts     (result.attempts),
    .fault        (result.fault)
);

[tb/sv/tb_bus_recovery_supervisor.sv]
`timescale 1ns / 1ps

module tb_bus_recovery_supervisor;
    import brs_pkg::*;

    localparam logic [OUTCOME_W-1:0] OUTCOME_BUSY  = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_SPARE = 2'd3;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [TIME_W-1:0]  entry;
        logic [CNT_W-1:0]   attempts;
        logic [SRC_W-1:0]   pending;
        logic [SRC_W-1:0]   done;
        logic               result_ready;
        logic               last_failed;
        logic [NMASK_W-1:0] notes;
        logic               bus_ok;
        logic               fault;
    } sup_state_t;

    logic clk;
    logic rst_n;

    brs_cfg_if    cfg_ch ();
    brs_item_if   item_ch ();
    brs_result_if res_ch ();

    bus_recovery_supervisor dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (res_ch)
    );

    sup_state_t sup = '{MODE_CODE_READY, '0, '0, '0, '0, 1'b0, 1'b0, '0, 1'b1, 1'b0};
    logic [TIME_W-1:0] retry_delay   = RESET_RETRY_DELAY;
    logic [CNT_W-1:0]  attempt_limit = RESET_ATTEMPT_LIMIT;

    result_t reply_q[$];
    int      bad_count = 0;
    bit      calm = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void enter_mode(logic [MODE_W-1:0] m, logic [TIME_W-1:0] now);
        if (sup.mode != m)
        begin
            sup.mode  = m;
            sup.entry = now;
        end
    endfunction

    function automatic void raise_notice(logic [NOTE_W-1:0] n);
        sup.notes = sup.notes | (NMASK_W'(1) << (n - 1));
    endfunction

    function automatic void close_episode(logic failed, logic [TIME_W-1:0] now);
        sup.last_failed  = failed;
        sup.result_ready = 1'b1;
        sup.done         = sup.pending;
        sup.pending      = '0;
        sup.fault        = failed;
        enter_mode(sup.bus_ok ? MODE_CODE_READY : MODE_CODE_ERROR, now);
        raise_notice(failed ? NOTE_FAILED : NOTE_SUCCEEDED);
    endfunction

    function automatic result_t step_supervisor(item_t it);
        result_t          r;
        logic [SRC_W-1:0] src;
        r = '0;
        case (it.func)
            FUNC_SERVICE:
            begin
                if (sup.mode == MODE_CODE_WAIT)
                begin
                    if (TIME_W'(it.now_ms - sup.entry) >= retry_delay)
                    begin
                        if (sup.attempts >= attempt_limit)
                            close_episode(1'b1, it.now_ms);
                        else
                        begin
                            sup.attempts  = sup.attempts + 1'b1;
                            r.start_pulse = 1'b1;
                            if (it.start_accepted)
                            begin
                                enter_mode(MODE_CODE_RECOVERING, it.now_ms);
                                raise_notice(NOTE_STARTED);
                            end
                            else if (sup.attempts < attempt_limit)
                            begin
                                sup.entry = it.now_ms;
                                raise_notice(NOTE_RETRY);
                            end
                            else
                            begin
                                r.reinit_pulse = 1'b1;
                                sup.bus_ok     = it.reinit_ok;
                                close_episode(1'b1, it.now_ms);
                            end
                        end
                    end
                end
                else if (sup.mode == MODE_CODE_RECOVERING)
                begin
                    if (it.engine_outcome == OUTCOME_SUCCEEDED)
                    begin
                        r.reinit_pulse = 1'b1;
                        sup.bus_ok     = it.reinit_ok;
                        close_episode(!it.reinit_ok, it.now_ms);
                    end
                    else if (it.engine_outcome == OUTCOME_FAILED)
                    begin
                        r.reinit_pulse = 1'b1;
                        sup.bus_ok     = it.reinit_ok;
                        if (sup.attempts < attempt_limit)
                        begin
                            enter_mode(MODE_CODE_WAIT, it.now_ms);
                            raise_notice(NOTE_RETRY);
                        end
                        else
                            close_episode(1'b1, it.now_ms);
                    end
                end
            end
            FUNC_REQUEST:
            begin
                src = it.request_sources & SRC_MASK;
                if (src != '0 && sup.mode != MODE_CODE_ERROR)
                begin
                    r.accepted  = 1'b1;
                    sup.pending = sup.pending | src;
                    if (sup.mode != MODE_CODE_WAIT && sup.mode != MODE_CODE_RECOVERING)
                    begin
                        sup.attempts     = '0;
                        sup.result_ready = 1'b0;
                        sup.done         = '0;
                        enter_mode(MODE_CODE_WAIT, it.now_ms);
                        raise_notice(NOTE_PENDING);
                    end
                end
            end
            FUNC_TAKE_RESULT:
            begin
                if (sup.result_ready)
                begin
                    r.accepted       = 1'b1;
                    r.result_code    = sup.last_failed;
                    r.result_sources = sup.done;
                    sup.result_ready = 1'b0;
                end
            end
            default:
            begin
                // pop the lowest pending notification
                for (int k = 0; k < NMASK_W; k++)
                begin
                    if (sup.notes[k])
                    begin
                        sup.notes[k] = 1'b0;
                        r.notice     = NOTE_W'(k + 1);
                        r.accepted   = 1'b1;
                        break;
                    end
                end
            end
        endcase
        r.mode     = sup.mode;
        r.attempts = sup.attempts;
        r.fault    = sup.fault;
        return r;
    endfunction

    // ---------------------------------------------------------------- drivers

    function automatic item_t cmd(func_t f, logic [TIME_W-1:0] now, logic [SRC_W-1:0] src,
                                  logic start_ok, logic [OUTCOME_W-1:0] outcome,
                                  logic reinit);
        item_t it;
        it.func            = f;
        it.now_ms          = now;
        it.request_sources = src;
        it.start_accepted  = start_ok;
        it.engine_outcome  = outcome;
        it.reinit_ok       = reinit;
        return it;
    endfunction

    task automatic push_item(input item_t it);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid           <= 1'b1;
        item_ch.func            <= it.func;
        item_ch.now_ms          <= it.now_ms;
        item_ch.request_sources <= it.request_sources;
        item_ch.start_accepted  <= it.start_accepted;
        item_ch.engine_outcome  <= it.engine_outcome;
        item_ch.reinit_ok       <= it.reinit_ok;
        do @(posedge clk); while (item_ch.ready !== 1'b1);
        reply_q.push_back(step_supervisor(it));
    endtask

    // Hold the item channel until every reply has come back.
    task automatic settle();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (reply_q.size() != 0);
    endtask

    task automatic load_settings(input logic [TIME_W-1:0] delay, input logic [CNT_W-1:0] limit);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_RETRY_DELAY;
        cfg_ch.data  <= delay;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        retry_delay = delay;
        cfg_ch.index <= REG_ATTEMPT_LIMIT;
        cfg_ch.data  <= CFG_DATA_W'(limit);
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        attempt_limit = limit;
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly well-formed traffic steered by the current mode, some pure noise.
    function automatic item_t pick_item(int start_odds);
        item_t             it;
        int                roll;
        logic [TIME_W-1:0] span;
        roll               = $urandom_range(0, 99);
        it.func            = func_t'($urandom_range(0, 3));
        it.now_ms          = $urandom;
        it.request_sources = SRC_W'($urandom_range(0, 3));
        it.start_accepted  = ($urandom_range(0, 99) < start_odds);
        it.engine_outcome  = OUTCOME_W'($urandom_range(0, 3));
        it.reinit_ok       = 1'($urandom_range(0, 1));
        if (roll >= 12)
        begin
            if (roll < 22)
                it.func = FUNC_TAKE_RESULT;
            else if (roll < 32)
                it.func = FUNC_TAKE_NOTICE;
            else if (sup.mode == MODE_CODE_READY || roll < 40)
                it.func = FUNC_REQUEST;
            else
                it.func = FUNC_SERVICE;
            if (it.func == FUNC_SERVICE && sup.mode == MODE_CODE_WAIT)
            begin
                if (roll < 75)
                begin
                    span = retry_delay + $urandom_range(0, 2);
                    if (span < retry_delay)
                        span = retry_delay;
                end
                else
                    span = $urandom % retry_delay;
                it.now_ms = sup.entry + span;
            end
        end
        // keep the bus usable until the error test
        if (it.func == FUNC_SERVICE && sup.mode != MODE_CODE_READY && sup.mode != MODE_CODE_ERROR)
            it.reinit_ok = 1'b1;
        return it;
    endfunction

    // ---------------------------------------------------------------- checker

    function automatic string show(result_t r);
        return $sformatf("acc=%0d mode=%0d start=%0d reinit=%0d code=%0d src=%0d note=%0d att=%0d fault=%0d",
                         r.accepted, r.mode, r.start_pulse, r.reinit_pulse, r.result_code,
                         r.result_sources, r.notice, r.attempts, r.fault);
    endfunction

    initial
    begin
        int hold;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(1, 19);
                res_ch.ready <= 1'b0;
                repeat (hold - 1) @(posedge clk);
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_reply
        result_t got;
        result_t want;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            got = '{res_ch.accepted, res_ch.mode, res_ch.start_pulse, res_ch.reinit_pulse,
                    res_ch.result_code, res_ch.result_sources, res_ch.notice,
                    res_ch.attempts, res_ch.fault};
            if (reply_q.size() == 0)
            begin
                bad_count++;
                if (bad_count <= 10)
                    $display("reply with nothing outstanding: %s", show(got));
            end
            else
            begin
                want = reply_q.pop_front();
                if (got !== want)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("reply mismatch at %0t\n  exp %s\n  got %s",
                                 $realtime, show(want), show(got));
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_default_episode();
        push_item(cmd(FUNC_SERVICE, 32'd5, 2'd0, 1'b1, OUTCOME_SUCCEEDED, 1'b0));
        push_item(cmd(FUNC_REQUEST, 32'd7, 2'd0, 1'b0, OUTCOME_BUSY, 1'b0));
        push_item(cmd(FUNC_TAKE_RESULT, 32'd8, 2'd0, 1'b0, OUTCOME_BUSY, 1'b0));
        push_item(cmd(FUNC_TAKE_NOTICE, 32'd9, 2'd0, 1'b0, OUTCOME_BUSY, 1'b0));
        push_item(cmd(FUNC_REQUEST, 32'd100, 2'd1, 1'b0, OUTCOME_BUSY, 1'b1));
        push_item(cmd(FUNC_SERVICE, 32'd109, 2'd0, 1'b1, OUTCOME_BUSY, 1'b1));
        push_item(cmd(FUNC_SERVICE, 32'd110, 2'd0, 1'b1, OUTCOME_BUSY, 1'b1));
        push_item(cmd(FUNC_SERVICE, 32'd115, 2'd0, 1'b0, OUTCOME_SPARE, 1'b1));
        push_item(cmd(FUNC_SERVICE, 32'd130, 2'd0, 1'b0, OUTCOME_FAILED, 1'b1));
        push_item(cmd(FUNC_REQUEST, 32'd131, 2'd2, 1'b0, OUTCOME_BUSY, 1'b1));
        push_item(cmd(FUNC_SERVICE, 32'd140, 2'd0, 1'b0, OUTCOME_BUSY, 1'b1));
        push_item(cmd(FUNC_SERVICE, 32'd150, 2'd0, 1'b1, OUTCOME_BUSY, 1'b1));
        push_item(cmd(FUNC_SERVICE, 32'd160, 2'd0, 1'b0, OUTCOME_SUCCEEDED, 1'b1));
        push_item(cmd(FUNC_TAKE_RESULT, 32'd161, 2'd3, 1'b0, OUTCOME_BUSY, 1'b0));
        push_item(cmd(FUNC_TAKE_RESULT, 32'd162, 2'd3, 1'b0, OUTCOME_BUSY, 1'b0));
        repeat (5) push_item(cmd(FUNC_TAKE_NOTICE, 32'd163, 2'd0, 1'b0, OUTCOME_BUSY, 1'b0));
    endtask

    task automatic test_attempt_limit();
        load_settings(32'd1, 8'd1);
        // engine failure at the limit closes the episode at once
        push_item(cmd(FUNC_REQUEST, 32'd0, 2'd3, 1'b0, OUTCOME_BUSY, 1'b1));
        push_item(cmd(FUNC_SERVICE, 32'd1, 2'd0, 1'b1, OUTCOME_BUSY, 1'b1));
        push_item(cmd(FUNC_SERVICE, 32'd2, 2'd0, 1'b0, OUTCOME_FAILED, 1'b1));
        push_item(cmd(FUNC_TAKE_RESULT, 32'd3, 2'd0, 1'b0, OUTCOME_BUSY, 1'b1));
        // refused start on the last attempt reinits and fails
        push_item(cmd(FUNC_REQUEST, 32'd10, 2'd1, 1'b0, OUTCOME_BUSY, 1'b1));
        push_item(cmd(FUNC_SERVICE, 32'd11, 2'd0, 1'b0, OUTCOME_BUSY, 1'b1));
        // lower the limit under a waiting episode: the wait ends without a start
        load_settings(32'd5, 8'd3);
        push_item(cmd(FUNC_REQUEST, 32'd20, 2'd2, 1'b0, OUTCOME_BUSY, 1'b1));
        push_item(cmd(FUNC_SERVICE, 32'd25, 2'd0, 1'b0, OUTCOME_BUSY, 1'b1));
        push_item(cmd(FUNC_SERVICE, 32'd30, 2'd0, 1'b0, OUTCOME_BUSY, 1'b1));
        load_settings(32'd5, 8'd1);
        push_item(cmd(FUNC_SERVICE, 32'd35, 2'd0, 1'b1, OUTCOME_BUSY, 1'b1));
        push_item(cmd(FUNC_TAKE_RESULT, 32'd36, 2'd0, 1'b0, OUTCOME_BUSY, 1'b1));
    endtask

    task automatic test_time_wrap();
        load_settings(32'd20, 8'd3);
        push_item(cmd(FUNC_REQUEST, 32'hFFFF_FFF8, 2'd1, 1'b0, OUTCOME_BUSY, 1'b1));
        push_item(cmd(FUNC_SERVICE, 32'h0000_000B, 2'd0, 1'b1, OUTCOME_BUSY, 1'b1));
        push_item(cmd(FUNC_SERVICE, 32'h0000_000C, 2'd0, 1'b1, OUTCOME_BUSY, 1'b1));
        push_item(cmd(FUNC_SERVICE, 32'h0000_000D, 2'd0, 1'b0, OUTCOME_SUCCEEDED, 1'b1));
        load_settings(32'hFFFF_FFFF, 8'd255);
        push_item(cmd(FUNC_REQUEST, 32'h1234_5678, 2'd2, 1'b0, OUTCOME_BUSY, 1'b1));
        push_item(cmd(FUNC_SERVICE, 32'h1234_5676, 2'd0, 1'b1, OUTCOME_BUSY, 1'b1));
        push_item(cmd(FUNC_SERVICE, 32'h1234_5677, 2'd0, 1'b1, OUTCOME_BUSY, 1'b1));
        push_item(cmd(FUNC_SERVICE, 32'hEDCB_A987, 2'd0, 1'b0, OUTCOME_SUCCEEDED, 1'b1));
    endtask

    task automatic test_random_traffic(input int count, input int start_odds);
        repeat (count) push_item(pick_item(start_odds));
    endtask

    task automatic test_bus_error();
        // finish any open episode cleanly first
        while (sup.mode == MODE_CODE_WAIT || sup.mode == MODE_CODE_RECOVERING)
        begin
            if (sup.mode == MODE_CODE_WAIT)
                push_item(cmd(FUNC_SERVICE, sup.entry + retry_delay, 2'd0, 1'b1,
                              OUTCOME_BUSY, 1'b1));
            else
                push_item(cmd(FUNC_SERVICE, sup.entry, 2'd0, 1'b0, OUTCOME_SUCCEEDED, 1'b1));
        end
        push_item(cmd(FUNC_REQUEST, 32'h8000_0000, 2'd2, 1'b0, OUTCOME_BUSY, 1'b1));
        push_item(cmd(FUNC_SERVICE, 32'h8000_0000 + retry_delay, 2'd0, 1'b1, OUTCOME_BUSY, 1'b1));
        push_item(cmd(FUNC_SERVICE, 32'h8000_0001, 2'd0, 1'b0, OUTCOME_SUCCEEDED, 1'b0));
        push_item(cmd(FUNC_REQUEST, 32'h8000_0002, 2'd3, 1'b1, OUTCOME_BUSY, 1'b1));
        push_item(cmd(FUNC_SERVICE, 32'h8000_0003, 2'd0, 1'b1, OUTCOME_FAILED, 1'b1));
        push_item(cmd(FUNC_TAKE_RESULT, 32'h8000_0004, 2'd0, 1'b0, OUTCOME_BUSY, 1'b0));
        repeat (3) push_item(cmd(FUNC_TAKE_NOTICE, 32'h8000_0005, 2'd0, 1'b0, OUTCOME_BUSY, 1'b0));
        test_random_traffic(20, 50);
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        rst_n                   = 1'b0;
        item_ch.valid           = 1'b0;
        item_ch.func            = FUNC_SERVICE;
        item_ch.now_ms          = '0;
        item_ch.request_sources = '0;
        item_ch.start_accepted  = 1'b0;
        item_ch.engine_outcome  = OUTCOME_BUSY;
        item_ch.reinit_ok       = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = REG_RETRY_DELAY;
        cfg_ch.data             = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_episode();
        test_attempt_limit();
        test_time_wrap();

        load_settings(TIME_W'($urandom_range(1, 16)), CNT_W'($urandom_range(1, 6)));
        test_random_traffic(120, 50);
        load_settings(32'd1, 8'd255);
        test_random_traffic(60, 8);
        load_settings(TIME_W'($urandom_range(1, 40)), CNT_W'($urandom_range(2, 8)));
        test_random_traffic(100, 60);

        // last stretch runs back to back on both sides
        calm = 1'b1;
        load_settings(TIME_W'($urandom_range(1, 32'hFFFF_FFFF)), CNT_W'($urandom_range(1, 255)));
        test_random_traffic(60, 50);
        test_bus_error();

        settle();
        repeat (8) @(posedge clk);
        bad_count += reply_q.size();
        if (bad_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
hdl/brs_pkg.sv
hdl/brs_ifs.sv
hdl/brs_step.sv
hdl/bus_recovery_supervisor.sv
hdl/brs_checker.sv
tb/sv/tb_bus_recovery_supervisor.sv
